// ===== sv/depth_to_time_trace_resampler_defines.svh =====
// ----------------------------------------------------------------------------
// Depth-to-time trace resampler: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_TIME_TRACE_RESAMPLER_DEFINES_SVH
`define DEPTH_TO_TIME_TRACE_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("resampler port check failed");

// Next-cycle implication, disabled during reset.
`define DTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("resampler port check failed");

`endif

// ===== sv/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth-to-time trace resampler package
// Field widths, payload structs, register indexes and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package dtr_pkg;

  localparam int unsigned VEL_W         = 16;
  localparam int unsigned AMP_W         = 32;
  localparam int unsigned IDX_W         = 16;
  localparam int unsigned OUT_LEN_W     = 16;
  localparam int unsigned TSS_W         = 40;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned MAG_W         = AMP_W + 1;
  localparam int unsigned VEL_FRAC_BITS = 16;
  localparam int unsigned CFG_W         = 40;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN         = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP_SCALE = 1'b1;

  localparam logic [OUT_LEN_W-1:0] OUT_LEN_RST = 16'hFFFF;
  localparam logic [TSS_W-1:0]     TSS_RST     = 40'd1310720000;

  typedef struct packed {
    logic [VEL_W-1:0]        velocity;
    logic signed [AMP_W-1:0] amplitude;
    logic                    first_of_trace;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        sample_index;
    logic signed [AMP_W-1:0] sample_value;
    logic                    last_of_burst;
    logic                    burst_truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_TIME,
    S_SETUP1,
    S_SETUP2,
    S_MD_FIRST,
    S_MD_STEP,
    S_EMIT
  } dtr_state_e;

  typedef struct packed {
    logic accept;
    logic time_load;
    logic setup1;
    logic setup2;
    logic md_start;
    logic md_step_sel;
    logic md_save_first;
    logic md_save_step;
    logic emit;
  } dtr_cmd_t;

  typedef struct packed {
    logic first;
    logic out_len_zero;
    logic div_done;
    logic none;
    logic md_done;
    logic last_out;
    logic out_free;
  } dtr_status_t;

endpackage

`default_nettype wire

// ===== sv/dtr_div.sv =====
// ----------------------------------------------------------------------------
// Traveltime increment divider
// Restoring divide of the scaled step by the velocity, four quotient bits a
// cycle, result saturated to the time width.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_div #(
  parameter int unsigned NW = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NW-1:0]                 num_i,
  input  logic [dtr_pkg::VEL_W-1:0]     den_i,
  output logic                          done_o,
  output logic [dtr_pkg::TIME_W-1:0]    quo_o
);
  import dtr_pkg::*;

  localparam int unsigned BPC   = 4;
  localparam int unsigned NP    = ((NW + BPC - 1) / BPC) * BPC;
  localparam int unsigned STEPS = NP / BPC;
  localparam int unsigned CNTW  = $clog2(STEPS + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [NP-1:0]    nq_q, nq_w;
  logic [VEL_W-1:0] rem_q, rem_w;
  logic [VEL_W-1:0] den_q;
  logic [VEL_W:0]   trial;

  // shift dividend bits out of the top, quotient bits into the bottom
  always_comb begin
    nq_w  = nq_q;
    rem_w = rem_q;
    trial = '0;
    for (int i = 0; i < BPC; i++) begin
      trial = {rem_w, nq_w[NP-1]};
      nq_w  = {nq_w[NP-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        nq_w[0]  = 1'b1;
      end
      rem_w = trial[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= NP'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= nq_w;
      rem_q <= rem_w;
    end
  end

  assign done_o = done_q;
  assign quo_o  = ((nq_q >> TIME_W) != '0) ? '1 : nq_q[TIME_W-1:0];

endmodule

`default_nettype wire

// ===== sv/dtr_muldiv.sv =====
// ----------------------------------------------------------------------------
// Serial multiply-divide
// Computes floor(a * b / d) and its remainder, two multiplier bits a cycle,
// with b no larger than d.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_muldiv #(
  parameter int unsigned BW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dtr_pkg::MAG_W-1:0]     a_i,
  input  logic [BW-1:0]                 b_i,
  input  logic [dtr_pkg::TIME_W-1:0]    d_i,
  output logic                          done_o,
  output logic [dtr_pkg::MAG_W-1:0]     q_o,
  output logic [dtr_pkg::TIME_W-1:0]    r_o
);
  import dtr_pkg::*;

  localparam int unsigned BPC   = 2;
  localparam int unsigned AP    = ((MAG_W + BPC - 1) / BPC) * BPC;
  localparam int unsigned STEPS = AP / BPC;
  localparam int unsigned CNTW  = $clog2(STEPS + 1);
  localparam int unsigned TW    = TIME_W + 2;

  logic              busy_q;
  logic              done_q;
  logic [CNTW-1:0]   cnt_q;
  logic [AP-1:0]     a_q, a_w;
  logic [AP-1:0]     q_q, q_w;
  logic [TIME_W-1:0] r_q, r_w;
  logic [BW-1:0]     b_q;
  logic [TIME_W-1:0] d_q;
  logic [TW-1:0]     acc;
  logic [1:0]        qinc;

  // remainder stays below d, so 2r + b is below 3d: at most two subtracts
  always_comb begin
    a_w  = a_q;
    q_w  = q_q;
    r_w  = r_q;
    acc  = '0;
    qinc = '0;
    for (int i = 0; i < BPC; i++) begin
      acc  = {1'b0, r_w, 1'b0} + (a_w[AP-1] ? TW'(b_q) : '0);
      qinc = 2'd0;
      if (acc >= TW'(d_q)) begin
        acc  = acc - TW'(d_q);
        qinc = 2'd1;
      end
      if (acc >= TW'(d_q)) begin
        acc  = acc - TW'(d_q);
        qinc = qinc + 2'd1;
      end
      r_w = acc[TIME_W-1:0];
      q_w = {q_w[AP-2:0], 1'b0} + AP'(qinc);
      a_w = {a_w[AP-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= AP'(a_i);
      b_q <= b_i;
      d_q <= d_i;
      q_q <= '0;
      r_q <= '0;
    end else if (busy_q) begin
      a_q <= a_w;
      q_q <= q_w;
      r_q <= r_w;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q[MAG_W-1:0];
  assign r_o    = r_q;

endmodule

`default_nettype wire

// ===== sv/dtr_datapath.sv =====
// ----------------------------------------------------------------------------
// Resampler datapath
// Configuration registers, trace state, burst setup, interpolation stepping
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_datapath #(
  parameter int unsigned MAX_BURST      = 64,
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dtr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dtr_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  dtr_pkg::in_item_t                 in_data_i,
  input  dtr_pkg::dtr_cmd_t                 cmd_i,
  output dtr_pkg::dtr_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dtr_pkg::out_item_t                out_data_o
);
  import dtr_pkg::*;

  localparam int unsigned TFB  = TIME_FRAC_BITS;
  localparam int unsigned NW   = TSS_W + TFB - VEL_FRAC_BITS;
  localparam int unsigned KW   = TIME_W - TFB;
  localparam int unsigned CMPW = KW + IDX_W;
  localparam int unsigned CW   = $clog2(MAX_BURST + 1);

  // configuration and trace state
  logic [OUT_LEN_W-1:0]    out_len_q;
  logic [TSS_W-1:0]        tss_q;
  logic [TIME_W-1:0]       trace_time_q;
  logic signed [AMP_W-1:0] prev_amp_q;

  // per-item working registers
  logic [TIME_W-1:0]       t0_q, t1_q, span_q;
  logic signed [AMP_W-1:0] amp_q, y0_q;
  logic [IDX_W-1:0]        last_idx_q, j_q;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;
  logic [TFB:0]            frac0_q;
  logic [CW-1:0]           cnt_q;
  logic                    trunc_q;
  logic [MAG_W-1:0]        q_q, qs_q;
  logic [TIME_W-1:0]       rem_q, rs_q;
  logic                    out_valid_q;
  out_item_t               out_data_q;

  // divider and multiply-divide hookup
  logic [TSS_W+TFB-1:0]    tss_ext;
  logic [NW-1:0]           div_num;
  logic [VEL_W-1:0]        div_den;
  logic                    div_start, div_done;
  logic [TIME_W-1:0]       delta;
  logic [TFB:0]            frac_one;
  logic                    md_done;
  logic [MAG_W-1:0]        md_q;
  logic [TIME_W-1:0]       md_r;

  // combinational helpers
  logic [TIME_W:0]         t_sum;
  logic [TIME_W-1:0]       t1_sat;
  logic [OUT_LEN_W-1:0]    out_len_m1;
  logic [CMPW-1:0]         k2_ext, lim_ext, k1_ext, li_ext;
  logic [MAG_W-1:0]        diff;
  logic [IDX_W-1:0]        k1_idx, raw_cnt;
  logic                    covers;
  logic [MAG_W:0]          val_ext;
  logic [TIME_W:0]         rem_sum;
  logic                    rem_carry;

  assign tss_ext   = {tss_q, {TFB{1'b0}}};
  assign div_num   = tss_ext[TSS_W+TFB-1:VEL_FRAC_BITS];
  assign div_den   = (in_data_i.velocity == '0) ? VEL_W'(1) : in_data_i.velocity;
  assign div_start = cmd_i.accept && !in_data_i.first_of_trace;
  assign frac_one  = {1'b1, {TFB{1'b0}}};

  dtr_div #(
    .NW(NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (delta)
  );

  dtr_muldiv #(
    .BW(TFB + 1)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (mag_q),
    .b_i     (cmd_i.md_step_sel ? frac_one : frac0_q),
    .d_i     (span_q),
    .done_o  (md_done),
    .q_o     (md_q),
    .r_o     (md_r)
  );

  // saturating time update
  assign t_sum  = {1'b0, t0_q} + {1'b0, delta};
  assign t1_sat = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];

  // last grid index within range
  assign out_len_m1 = out_len_q - OUT_LEN_W'(1);
  assign k2_ext     = CMPW'(t1_q[TIME_W-1:TFB]);
  assign lim_ext    = CMPW'(out_len_m1);
  assign diff       = {amp_q[AMP_W-1], amp_q} - {y0_q[AMP_W-1], y0_q};

  // burst length
  assign k1_ext  = CMPW'(t0_q[TIME_W-1:TFB]);
  assign li_ext  = CMPW'(last_idx_q);
  assign covers  = k1_ext < li_ext;
  assign k1_idx  = k1_ext[IDX_W-1:0];
  assign raw_cnt = last_idx_q - k1_idx;

  // interpolated value and next quotient step
  assign val_ext   = neg_q ? ({y0_q[AMP_W-1], y0_q[AMP_W-1], y0_q} - {1'b0, q_q})
                           : ({y0_q[AMP_W-1], y0_q[AMP_W-1], y0_q} + {1'b0, q_q});
  assign rem_sum   = {1'b0, rem_q} + {1'b0, rs_q};
  assign rem_carry = rem_sum >= {1'b0, span_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q    <= OUT_LEN_RST;
      tss_q        <= TSS_RST;
      trace_time_q <= '0;
      prev_amp_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OUT_LEN:         out_len_q <= cfg_wdata_i[OUT_LEN_W-1:0];
          CFG_TIME_STEP_SCALE: tss_q     <= cfg_wdata_i[TSS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        prev_amp_q <= in_data_i.amplitude;
        if (in_data_i.first_of_trace) begin
          trace_time_q <= '0;
        end
      end
      if (cmd_i.time_load) begin
        trace_time_q <= t1_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t0_q  <= trace_time_q;
      amp_q <= in_data_i.amplitude;
      if (in_data_i.first_of_trace) begin
        // single result at index zero carrying the sample itself
        y0_q    <= in_data_i.amplitude;
        q_q     <= '0;
        neg_q   <= 1'b0;
        j_q     <= '0;
        cnt_q   <= CW'(1);
        trunc_q <= 1'b0;
      end else begin
        y0_q <= prev_amp_q;
      end
    end
    if (cmd_i.time_load) begin
      t1_q <= t1_sat;
    end
    if (cmd_i.setup1) begin
      last_idx_q <= (k2_ext < lim_ext) ? k2_ext[IDX_W-1:0] : out_len_m1;
      neg_q      <= diff[MAG_W-1];
      mag_q      <= diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
      span_q     <= t1_q - t0_q;
      frac0_q    <= frac_one - {1'b0, t0_q[TFB-1:0]};
    end
    if (cmd_i.setup2) begin
      j_q <= k1_idx + IDX_W'(1);
      if (raw_cnt > IDX_W'(MAX_BURST)) begin
        cnt_q   <= CW'(MAX_BURST);
        trunc_q <= 1'b1;
      end else begin
        cnt_q   <= raw_cnt[CW-1:0];
        trunc_q <= 1'b0;
      end
    end
    if (cmd_i.md_save_first) begin
      q_q   <= md_q;
      rem_q <= md_r;
    end
    if (cmd_i.md_save_step) begin
      qs_q <= md_q;
      rs_q <= md_r;
    end
    if (cmd_i.emit) begin
      out_data_q.sample_index    <= j_q;
      out_data_q.sample_value    <= $signed(val_ext[AMP_W-1:0]);
      out_data_q.last_of_burst   <= (cnt_q == CW'(1));
      out_data_q.burst_truncated <= trunc_q;
      // advance one grid index: add the per-index quotient and carry
      j_q   <= j_q + IDX_W'(1);
      cnt_q <= cnt_q - CW'(1);
      q_q   <= q_q + qs_q + MAG_W'(rem_carry);
      rem_q <= rem_carry ? (rem_sum[TIME_W-1:0] - span_q) : rem_sum[TIME_W-1:0];
    end
  end

  assign status_o.first        = in_data_i.first_of_trace;
  assign status_o.out_len_zero = (out_len_q == '0);
  assign status_o.div_done     = div_done;
  assign status_o.none         = (out_len_q == '0) || !covers;
  assign status_o.md_done      = md_done;
  assign status_o.last_out     = (cnt_q == CW'(1));
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/dtr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Resampler controller
// Sequences accept, divide, burst setup, the two multiply-divides and the
// result burst.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dtr_pkg::dtr_status_t  status_i,
  output dtr_pkg::dtr_cmd_t     cmd_o
);
  import dtr_pkg::*;

  dtr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.first) begin
            state_d = status_i.out_len_zero ? S_IDLE : S_EMIT;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_TIME;
        end
      end
      S_TIME:   state_d = S_SETUP1;
      S_SETUP1: state_d = S_SETUP2;
      S_SETUP2: state_d = status_i.none ? S_IDLE : S_MD_FIRST;
      S_MD_FIRST: begin
        if (status_i.md_done) begin
          state_d = S_MD_STEP;
        end
      end
      S_MD_STEP: begin
        if (status_i.md_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free && status_i.last_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.accept    = in_valid_i;
      S_DIV:    ;
      S_TIME:   cmd_o.time_load = 1'b1;
      S_SETUP1: cmd_o.setup1    = 1'b1;
      S_SETUP2: begin
        cmd_o.setup2   = 1'b1;
        cmd_o.md_start = !status_i.none;
      end
      S_MD_FIRST: begin
        // keep the first quotient, then start the per-index step
        if (status_i.md_done) begin
          cmd_o.md_save_first = 1'b1;
          cmd_o.md_start      = 1'b1;
          cmd_o.md_step_sel   = 1'b1;
        end
      end
      S_MD_STEP: cmd_o.md_save_step = status_i.md_done;
      S_EMIT:    cmd_o.emit         = status_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/depth_to_time_trace_resampler.sv =====
// ----------------------------------------------------------------------------
// Depth-to-time trace resampler
// Converts depth samples of a trace to a uniform two-way time grid by linear
// interpolation.
// ----------------------------------------------------------------------------
// Input channel: one depth sample (velocity, amplitude, first_of_trace) per
// transaction, taken when in_valid_i is high and in_stall_o is low.
// Output channel: zero or more grid samples per input transaction, the last
// one flagged with last_of_burst, each held in an output register until the
// receiver drops out_stall_i.
// A first-of-trace sample gives one result, index 0 with its own amplitude,
// or none while out_len is zero. Any other sample goes through the divider
// (4 quotient bits a cycle), the time update, burst setup and two runs of the
// shared multiply-divide unit before its first result, then gives one result
// per cycle while the receiver does not stall.
// The block takes one sample at a time; it accepts the next sample while the
// final result of the previous one still waits in the output register.
// A stalled receiver holds the output register and pauses the burst.
// Reset clears trace time and previous amplitude to zero and loads the
// register defaults (out_len 65535, time_step_scale 20000.0).
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_time_trace_resampler #(
  parameter int unsigned MAX_BURST      = 64,
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dtr_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dtr_pkg::out_item_t             out_data_o
);
  import dtr_pkg::*;

  dtr_cmd_t    cmd;
  dtr_status_t status;

  dtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtr_datapath #(
    .MAX_BURST      (MAX_BURST),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/dtr_checker.sv =====
// ----------------------------------------------------------------------------
// Resampler port checker
// Watches the top-level ports for burst ordering and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_to_time_trace_resampler_defines.svh"

module dtr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_stall_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dtr_pkg::out_item_t  out_data_i
);

  // a stalled result stays offered
  `DTR_ASSERT_NEXT(a_out_valid_hold, out_valid_i && out_stall_i, out_valid_i)

  // within a burst the next result follows at once with the next grid index
  `DTR_ASSERT_NEXT(a_burst_index_step, out_valid_i && !out_stall_i && !out_data_i.last_of_burst, out_valid_i && (out_data_i.sample_index == $past(out_data_i.sample_index) + 16'd1))

  // the truncation flag is the same on every result of a burst
  `DTR_ASSERT_NEXT(a_burst_trunc_same, out_valid_i && !out_stall_i && !out_data_i.last_of_burst, out_data_i.burst_truncated == $past(out_data_i.burst_truncated))

  // no new sample is taken while a burst is still running
  `DTR_ASSERT_NOW(a_no_accept_in_burst, out_valid_i && !out_data_i.last_of_burst, in_stall_i)

endmodule

bind depth_to_time_trace_resampler dtr_checker u_dtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth-to-time trace resampler testbench
// Feeds depth samples through a table of directed corner cases and then
// through random traces under changing register settings. Every output
// transaction is checked against an in-bench model of the time accumulation
// and linear interpolation. Both sides idle at random, and at one point the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb;
  import dtr_pkg::*;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned BURST_CAP     = 64;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 69;
  localparam logic [TSS_W-1:0] SCALE_MAX = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_item_t             sample;
    logic                 fixed;
    out_item_t            fixed_result;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  // model state and register copies
  logic [TIME_W-1:0]    depth_time = '0;
  logic [AMP_W-1:0]     last_amp = '0;
  logic [OUT_LEN_W-1:0] cur_out_len = OUT_LEN_RST;
  logic [TSS_W-1:0]     cur_scale = TSS_RST;

  out_item_t   burst_q[$];
  out_item_t   pending_samples[$];
  int unsigned mismatches = 0;
  bit          steady_run = 1'b0;
  bit          hold_request = 1'b0;

  depth_to_time_trace_resampler #(
    .MAX_BURST     (BURST_CAP),
    .TIME_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the traveltime for one depth sample and fill burst_q with the
  // grid samples it newly covers.
  task automatic resample_depth_sample(input in_item_t it);
    logic [63:0]        vel, delta, t0, t1, k1, k2, last_idx, cnt, mag, span;
    logic [63:0]        n, grid, frac, q;
    logic signed [63:0] y0, y1, diff, val;
    logic               neg, trunc;
    out_item_t          r;
    burst_q.delete();
    y1 = {{32{it.amplitude[AMP_W-1]}}, it.amplitude};
    if (it.first_of_trace) begin
      depth_time = '0;
      last_amp = it.amplitude;
      r.sample_index = '0;
      r.sample_value = it.amplitude;
      r.last_of_burst = 1'b1;
      r.burst_truncated = 1'b0;
      if (cur_out_len != 0) burst_q.push_back(r);
      return;
    end
    vel = (it.velocity == 0) ? 64'd1 : {48'd0, it.velocity};
    delta = ({24'd0, cur_scale} << FRAC_BITS) / (vel << 16);
    if (delta > 64'hFFFF_FFFF) delta = 64'hFFFF_FFFF;
    t0 = {32'd0, depth_time};
    t1 = t0 + delta;
    if (t1 > 64'hFFFF_FFFF) t1 = 64'hFFFF_FFFF;
    y0 = {{32{last_amp[AMP_W-1]}}, last_amp};
    depth_time = t1[31:0];
    last_amp = it.amplitude;
    k1 = t0 >> FRAC_BITS;
    k2 = t1 >> FRAC_BITS;
    if (cur_out_len == 0) return;
    last_idx = k2;
    if (last_idx > {48'd0, cur_out_len} - 1) last_idx = {48'd0, cur_out_len} - 1;
    if (k1 + 1 > last_idx) return;
    cnt = last_idx - k1;
    trunc = cnt > BURST_CAP;
    if (trunc) cnt = BURST_CAP;
    diff = y1 - y0;
    neg = diff[63];
    mag = neg ? -diff : diff;
    span = t1 - t0;
    for (n = 0; n < cnt; n++) begin
      grid = k1 + 1 + n;
      frac = (grid << FRAC_BITS) - t0;
      q = (mag * frac) / span;
      val = neg ? y0 - $signed(q) : y0 + $signed(q);
      r.sample_index = grid[IDX_W-1:0];
      r.sample_value = val[AMP_W-1:0];
      r.last_of_burst = (n + 1 == cnt);
      r.burst_truncated = trunc;
      burst_q.push_back(r);
    end
  endtask

  task automatic send_sample(input in_item_t it, input logic fixed, input out_item_t want);
    while (!steady_run && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    resample_depth_sample(it);
    if (fixed) pending_samples.push_back(want);
    else foreach (burst_q[i]) pending_samples.push_back(burst_q[i]);
  endtask

  // Drain every expected sample, then give a sample with no result time to
  // finish inside the block.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_OUT_LEN) cur_out_len = val[OUT_LEN_W-1:0];
    else cur_scale = val[TSS_W-1:0];
  endtask

  task automatic check_sample(input out_item_t got);
    out_item_t want;
    if (pending_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transaction: index %0d value %0d last %0b trunc %0b",
                 got.sample_index, got.sample_value, got.last_of_burst,
                 got.burst_truncated);
      return;
    end
    want = pending_samples.pop_front();
    if (got.sample_index !== want.sample_index || got.sample_value !== want.sample_value ||
        got.last_of_burst !== want.last_of_burst ||
        got.burst_truncated !== want.burst_truncated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                 want.sample_index, want.sample_value, want.last_of_burst,
                 want.burst_truncated, got.sample_index, got.sample_value,
                 got.last_of_burst, got.burst_truncated);
    end
  endtask

  function automatic stim_row_t sample_row(input logic [VEL_W-1:0] v, input logic [AMP_W-1:0] a);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.sample.velocity = v;
    row.sample.amplitude = a;
    return row;
  endfunction

  // A trace start gives grid index 0 with its own amplitude while out_len is not zero.
  function automatic stim_row_t trace_start_row(input logic [AMP_W-1:0] a);
    stim_row_t row;
    row = sample_row(16'hFFFF, a);
    row.sample.first_of_trace = 1'b1;
    row.fixed = 1'b1;
    row.fixed_result.sample_value = a;
    row.fixed_result.last_of_burst = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // receiver: check, then pick the stall for the next cycle
  initial begin : sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_sample(out_data);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady_run && ($urandom_range(99) < 38);
      end
    end
  end

  initial begin : stimulus
    stim_row_t   rows[$];
    in_item_t    it;
    out_item_t   none;
    logic [63:0] v64;
    int unsigned total, phase_items, trace_len, n;
    none = '0;
    total = 0;
    rows = '{
      sample_row(16'd20000, 32'h0001_0000),   // continuation before any trace start
      trace_start_row(32'h7FFF_FFFF),
      sample_row(16'd0, 32'h8000_0000),       // zero velocity, capped burst
      sample_row(16'hFFFF, 32'h0000_0000),    // covers no grid index
      trace_start_row(32'h8000_0000),
      sample_row(16'd10000, 32'h7FFF_FFFF),
      sample_row(16'd7, 32'h1234_5678),
      sample_row(16'd40000, 32'hFFFF_FFFB),
      sample_row(16'd40000, 32'h0000_FFFF),
      reg_row(CFG_OUT_LEN, 40'd1),
      trace_start_row(32'h4000_0000),
      sample_row(16'd1, 32'h0000_0000),       // past out_len, dropped
      reg_row(CFG_OUT_LEN, 40'd3),
      trace_start_row(32'h0000_0000),
      sample_row(16'd5000, 32'h7FFF_FFFF),
      reg_row(CFG_OUT_LEN, 40'd65535),
      reg_row(CFG_TIME_STEP_SCALE, SCALE_MAX),
      trace_start_row(32'h0000_0001),
      sample_row(16'd1, 32'hFFFF_FFFF),       // time saturates
      sample_row(16'd0, 32'h7FFF_FFFF),       // saturated, nothing new
      reg_row(CFG_TIME_STEP_SCALE, 40'd1),
      trace_start_row(32'h0000_2000),
      sample_row(16'd0, 32'h0000_0003)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        settle_block();
        write_register(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_sample(rows[i].sample, rows[i].fixed, rows[i].fixed_result);
      end
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0: begin
          write_register(CFG_OUT_LEN, 40'd65535);
          write_register(CFG_TIME_STEP_SCALE, 40'd20000 << 16);
        end
        2: begin
          write_register(CFG_OUT_LEN, 40'd1);
          write_register(CFG_TIME_STEP_SCALE, {8'd0, 16'($urandom), 16'($urandom)});
        end
        3: begin
          write_register(CFG_OUT_LEN, 40'($urandom_range(1, 65535)));
          write_register(CFG_TIME_STEP_SCALE, SCALE_MAX);
        end
        default: begin
          write_register(CFG_OUT_LEN, 40'($urandom_range(1, 300)));
          write_register(CFG_TIME_STEP_SCALE,
                         {8'd0, 16'($urandom_range(1, 65535)), 16'($urandom)});
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        trace_len = $urandom_range(2, 25);
        for (n = 0; n < trace_len && phase_items < PHASE_ITEMS; n++) begin
          it.first_of_trace = (n == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 5);
          if ($urandom_range(99) < 80) begin
            // aim for a step of 1/16 to 3 grid samples
            v64 = ({24'd0, cur_scale >> 16} * 16) / $urandom_range(1, 48);
            if (v64 == 0) v64 = 1;
            if (v64 > 64'hFFFF) v64 = 64'hFFFF;
            it.velocity = v64[VEL_W-1:0];
          end else begin
            it.velocity = 16'($urandom);
          end
          case ($urandom_range(19))
            0: it.amplitude = 32'h7FFF_FFFF;
            1: it.amplitude = 32'h8000_0000;
            2: it.amplitude = 32'h0000_0000;
            default: it.amplitude = $urandom;
          endcase
          send_sample(it, 1'b0, none);
          phase_items++;
          total++;
          if (total == 100) hold_request = 1'b1;
          steady_run = (total >= 200 && total < 280);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
